@@ rtl/core/fsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Focus stack fusion package
// Shared widths, luma weights and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // Coefficient width, signed Q3.12.
    localparam int PIX_W = 16;
    // Width of the reported image index.
    localparam int IDX_OUT_W = 4;
    // Luma magnitude width, Q3.24 absolute value.
    localparam int MAG_W = 27;
    // Width of one signed weighted product and of the three-term sum.
    localparam int PROD_W = 29;

    // Luma weights in Q0.12; they add up to 4096.
    localparam logic signed [PROD_W-1:0] W_RED   = 29'sd1225;
    localparam logic signed [PROD_W-1:0] W_GREEN = 29'sd2404;
    localparam logic signed [PROD_W-1:0] W_BLUE  = 29'sd467;
    localparam logic [MAG_W-1:0]         MAG_MAX = {MAG_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // register the incoming transaction and its products
        logic accumulate;  // update sums, best selection and image count
        logic div_load;    // load the divider with the channel sum magnitudes
        logic div_step;    // one restoring division step on all channels
        logic load_out;    // load the result register
        logic clear;       // clear the per-pixel accumulation state
    } fsp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op;          // mode of the captured transaction
        logic last;        // captured transaction closes the stack
    } fsp_status_t;

endpackage

@@ rtl/core/fsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Focus stack fusion controller
// Sequences capture, accumulation, the averaging divide and result hand-off.
// ----------------------------------------------------------------------------
module fsp_ctrl
    import fsp_pkg::*;
#(
    parameter int SUM_W = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  fsp_status_t status,
    output fsp_cmd_t    cmd
);

    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ACC   = 5'b00010,
        ST_DLOAD = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.accumulate = 1'b1;
                if (!status.last) begin
                    state_next = ST_IDLE;
                end else if (status.op) begin
                    state_next = ST_DLOAD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DLOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A pending result is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while a result is pending");

    // A new result only appears after the emit state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result valid without an emit step");

    // Accumulation always follows a capture.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |-> $past(cmd.capture))
        else $error("accumulation without a captured transaction");

    // The divider runs the full number of steps before the result is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && state_next == ST_EMIT) |-> (cnt_reg == CNT_W'(SUM_W - 1)))
        else $error("division ended early");
`endif

endmodule

@@ rtl/core/fsp_datapath.sv @@
// ----------------------------------------------------------------------------
// Focus stack fusion datapath
// Luma products, running sums, best-image selection, divider and result.
// ----------------------------------------------------------------------------
module fsp_datapath
    import fsp_pkg::*;
#(
    parameter int MAX_IMAGES = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fsp_cmd_t                cmd,
    output fsp_status_t             status,
    input  logic                    s_op,
    input  logic signed [PIX_W-1:0] s_red_in,
    input  logic signed [PIX_W-1:0] s_green_in,
    input  logic signed [PIX_W-1:0] s_blue_in,
    input  logic                    s_last_image,
    output logic signed [PIX_W-1:0] m_red_out,
    output logic signed [PIX_W-1:0] m_green_out,
    output logic signed [PIX_W-1:0] m_blue_out,
    output logic [IDX_OUT_W-1:0]    m_chosen_image
);

    localparam int CW    = $clog2(MAX_IMAGES + 1);
    localparam int BIW   = $clog2(MAX_IMAGES);
    localparam int SUM_W = PIX_W + $clog2(MAX_IMAGES);
    localparam int RW    = CW + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_IMAGES);

    logic signed [PIX_W-1:0]  pix_in [3];
    logic signed [PIX_W-1:0]  pix_reg [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic                     op_reg, last_reg;

    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [PIX_W-1:0]  best_reg [3];
    logic [MAG_W-1:0]         best_mag_reg;
    logic [BIW-1:0]           best_idx_reg;
    logic [CW-1:0]            count_reg;

    logic [SUM_W-1:0]         quo_reg [3];
    logic [RW-1:0]            rem_reg [3];
    logic                     neg_reg [3];

    logic signed [PROD_W-1:0] luma;
    logic [PROD_W-1:0]        luma_abs;
    logic [MAG_W-1:0]         mag;
    logic                     take_new;
    logic                     in_range;

    assign pix_in[0] = s_red_in;
    assign pix_in[1] = s_green_in;
    assign pix_in[2] = s_blue_in;

    assign status.op   = op_reg;
    assign status.last = last_reg;

    // Luma magnitude, saturated to the magnitude width.
    assign luma     = prod_reg[0] + prod_reg[1] + prod_reg[2];
    assign luma_abs = luma[PROD_W-1] ? PROD_W'(-luma) : PROD_W'(luma);
    assign mag      = (luma_abs > PROD_W'(MAG_MAX)) ? MAG_MAX : luma_abs[MAG_W-1:0];
    assign in_range = (count_reg < MAX_CNT);
    assign take_new = (count_reg == '0) || (mag > best_mag_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= s_op;
            last_reg    <= s_last_image;
            prod_reg[0] <= PROD_W'(s_red_in) * W_RED;
            prod_reg[1] <= PROD_W'(s_green_in) * W_GREEN;
            prod_reg[2] <= PROD_W'(s_blue_in) * W_BLUE;
            for (int c = 0; c < 3; c++) begin
                pix_reg[c] <= pix_in[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            best_mag_reg <= '0;
            best_idx_reg <= '0;
            count_reg    <= '0;
            for (int c = 0; c < 3; c++) begin
                sum_reg[c]  <= '0;
                best_reg[c] <= '0;
            end
        end else if (cmd.accumulate && in_range) begin
            count_reg <= count_reg + 1'b1;
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= sum_reg[c] + SUM_W'(pix_reg[c]);
            end
            if (take_new) begin
                best_mag_reg <= mag;
                best_idx_reg <= BIW'(count_reg);
                for (int c = 0; c < 3; c++) begin
                    best_reg[c] <= pix_reg[c];
                end
            end
        end
    end

    // Restoring division of the sum magnitudes by the image count, one
    // quotient bit per step on each channel lane.
    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            if (cmd.div_load) begin
                neg_reg[c] <= sum_reg[c][SUM_W-1];
                quo_reg[c] <= sum_reg[c][SUM_W-1] ? SUM_W'(-sum_reg[c]) : SUM_W'(sum_reg[c]);
                rem_reg[c] <= '0;
            end else if (cmd.div_step) begin
                if ({rem_reg[c][RW-2:0], quo_reg[c][SUM_W-1]} >= RW'(count_reg)) begin
                    rem_reg[c] <= {rem_reg[c][RW-2:0], quo_reg[c][SUM_W-1]} - RW'(count_reg);
                    quo_reg[c] <= {quo_reg[c][SUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[c] <= {rem_reg[c][RW-2:0], quo_reg[c][SUM_W-1]};
                    quo_reg[c] <= {quo_reg[c][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (op_reg) begin
                m_red_out      <= neg_reg[0] ? PIX_W'(-quo_reg[0]) : PIX_W'(quo_reg[0]);
                m_green_out    <= neg_reg[1] ? PIX_W'(-quo_reg[1]) : PIX_W'(quo_reg[1]);
                m_blue_out     <= neg_reg[2] ? PIX_W'(-quo_reg[2]) : PIX_W'(quo_reg[2]);
                m_chosen_image <= '0;
            end else begin
                m_red_out      <= best_reg[0];
                m_green_out    <= best_reg[1];
                m_blue_out     <= best_reg[2];
                m_chosen_image <= IDX_OUT_W'(best_idx_reg);
            end
        end
    end

endmodule

@@ rtl/core/focus_stack_pyramid_fusion.sv @@
// ----------------------------------------------------------------------------
// Focus stack pyramid coefficient fusion
// Fuses the RGB coefficients of one pixel position across a focus stack.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one image's RGB coefficient (signed
// Q3.12) for the current pixel, images in stack order, with s_last_image set
// on the final image. The transaction that closes the stack produces exactly
// one result transaction; all other input transactions produce none.
// With s_op low the result is the image whose absolute luma is strictly the
// greatest (earliest image on ties) and m_chosen_image gives its index. With
// s_op high the result is the per-channel average, truncated toward zero, and
// m_chosen_image is zero. Images past MAX_IMAGES in a stack are ignored.
// A transaction that does not close the stack passes through capture with the
// luma products, then accumulation, and s_ready stays low until the block is
// idle again. A closing one in detail mode then goes to the emit step; in top
// mode it first loads the restoring divider, which produces one quotient bit
// per cycle on all three channels, SUM_W = 16 + clog2(MAX_IMAGES), and then
// emits. The emit step waits until the output register is free.
// The result sits in an output register; a stalled receiver holds it and the
// next stack's images keep being accepted until another result is due.
// Reset (aresetn low, synchronous) clears the stack state and drops m_valid.
// ----------------------------------------------------------------------------
module focus_stack_pyramid_fusion
    import fsp_pkg::*;
#(
    parameter int MAX_IMAGES = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic signed [PIX_W-1:0] s_red_in,
    input  logic signed [PIX_W-1:0] s_green_in,
    input  logic signed [PIX_W-1:0] s_blue_in,
    input  logic                    s_last_image,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [PIX_W-1:0] m_red_out,
    output logic signed [PIX_W-1:0] m_green_out,
    output logic signed [PIX_W-1:0] m_blue_out,
    output logic [IDX_OUT_W-1:0]    m_chosen_image
);

    // Width of the per-channel running sums; the divider runs one step per bit.
    localparam int SUM_W = PIX_W + $clog2(MAX_IMAGES);

    fsp_cmd_t    cmd;
    fsp_status_t status;

    // The controller owns the handshakes and sequencing.
    fsp_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the stack state, the divider and the result register.
    fsp_datapath #(
        .MAX_IMAGES (MAX_IMAGES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_op           (s_op),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .s_last_image   (s_last_image),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out),
        .m_chosen_image (m_chosen_image)
    );

endmodule
